// File: sv/wlr_pkg.sv
`timescale 1ns / 1ps

package wlr_pkg;

    localparam int STEP_W          = 32;
    localparam int RATE_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int V_W             = FRAC_W + 1;
    localparam int COS_TABLE_DEPTH = 256;
    localparam int IDX_W           = $clog2(COS_TABLE_DEPTH + 1);
    localparam int POS_W           = V_W + IDX_W;
    localparam int PROD_W          = STEP_W + RATE_W;
    localparam int SPAN_W          = RATE_W + V_W;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PEAK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 3'd3;

    localparam logic [RATE_W-1:0] PEAK_RESET   = 32'd268435;
    localparam logic [RATE_W-1:0] FLOOR_RESET  = 32'd26844;
    localparam logic [STEP_W-1:0] WARMUP_RESET = STEP_W'(0);
    localparam logic [STEP_W-1:0] TOTAL_RESET  = STEP_W'(1);

    localparam logic [1:0] MODE_INVALID = 2'd0;
    localparam logic [1:0] MODE_WARM    = 2'd1;
    localparam logic [1:0] MODE_FLOOR   = 2'd2;
    localparam logic [1:0] MODE_DECAY   = 2'd3;

    localparam logic [V_W-1:0] ONE_Q16 = V_W'(65536);
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
    } t_tag;

    typedef struct packed {
        logic [STEP_W-1:0] rem;
        logic [RATE_W-1:0] acc;
        logic [STEP_W-1:0] dvsr;
        t_tag              tag;
    } t_div;

    typedef logic [COS_TABLE_DEPTH:0][V_W-1:0] t_rom;

    function automatic logic [63:0] series_div(input logic [63:0] a, input int i);
        logic [63:0] q;
        case (i)
            1:       q = a / 2;
            2:       q = a / 12;
            3:       q = a / 30;
            4:       q = a / 56;
            5:       q = a / 90;
            6:       q = a / 132;
            7:       q = a / 182;
            8:       q = a / 240;
            9:       q = a / 306;
            default: q = a / 380;
        endcase
        return q;
    endfunction

    function automatic logic [63:0] cos_quarter(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [65:0] sum;
        x    = (PI_Q30 * k) / COS_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed({2'b00, ONE_Q30});
        for (int i = 1; i <= 10; i++) begin
            term = series_div((term * x2) >> 30, i);
            if ((i % 2) == 1) begin
                sum = sum - $signed({2'b00, term});
            end else begin
                sum = sum + $signed({2'b00, term});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({2'b00, ONE_Q30})) begin
            sum = $signed({2'b00, ONE_Q30});
        end
        return sum[63:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] half;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            if (2 * k <= COS_TABLE_DEPTH) begin
                half = ONE_Q30 + cos_quarter(64'(k));
            end else begin
                half = ONE_Q30 - cos_quarter(64'(COS_TABLE_DEPTH - k));
            end
            rom[k] = V_W'((half + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

endpackage

// File: sv/wlr_ifs.sv
`timescale 1ns / 1ps

interface wlr_step_if;
    logic                      valid;
    logic                      ready;
    logic [wlr_pkg::STEP_W-1:0] step_index;
    modport source (output valid, output step_index, input ready);
    modport sink (input valid, input step_index, output ready);
endinterface

interface wlr_rate_if;
    logic                      valid;
    logic                      ready;
    logic [wlr_pkg::RATE_W-1:0] rate;
    logic                      status;
    modport source (output valid, output rate, output status, input ready);
    modport sink (input valid, input rate, input status, output ready);
endinterface

interface wlr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [wlr_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/warmup_cosine_lr_schedule.sv
`timescale 1ns / 1ps

// Learning-rate schedule with linear warmup and cosine decay to a floor.
// Step numbers come in on i_step and one result item (rate and status) leaves
// on o_rate for every step item, in order. i_cfg writes the peak rate, the floor
// rate, the warmup length and the total length; it is always ready and must be
// used only while no item is in flight.
// The pipeline has one setup stage with the 32x32 product, a chain of 32
// restoring-division cells that each resolve one quotient bit, two cosine
// table interpolation stages, one scaling multiply and the output register.
// A new item can enter in every cycle while the output is not stalled, so
// the throughput is one item per cycle. When the receiver stalls, the whole
// pipeline holds and i_step.ready drops until the output item is taken.
// Reset loads the default register values and empties the pipeline.

module warmup_cosine_lr_schedule (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wlr_cfg_if.sink   i_cfg,
    wlr_step_if.sink  i_step,
    wlr_rate_if.source o_rate
);
    import wlr_pkg::*;

    logic [RATE_W-1:0] r_peak;
    logic [RATE_W-1:0] r_floor;
    logic [STEP_W-1:0] r_warm;
    logic [STEP_W-1:0] r_total;

    logic              w_adv;
    logic [STEP_W-1:0] w_decay;
    logic [STEP_W-1:0] w_elapsed;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_dividend;
    t_div              n_div0;

    logic              r_vld0;
    t_div              r_div0;

    t_div              w_chain [0:RATE_W];
    logic              w_vld   [0:RATE_W];

    logic              w_vld_i;
    t_tag              w_tag_i;
    logic [RATE_W-1:0] w_quot_i;
    logic [V_W-1:0]    w_cos;

    logic              r_vld_c;
    t_tag              r_tag_c;
    logic [RATE_W-1:0] r_quot_c;
    logic [SPAN_W-1:0] r_span;

    logic              r_out_valid;
    logic [RATE_W-1:0] r_rate;
    logic              r_status;
    logic [RATE_W-1:0] n_rate;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= PEAK_RESET;
            r_floor <= FLOOR_RESET;
            r_warm  <= WARMUP_RESET;
            r_total <= TOTAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PEAK:   r_peak  <= i_cfg.data;
                REG_FLOOR:  r_floor <= i_cfg.data;
                REG_WARMUP: r_warm  <= i_cfg.data;
                REG_TOTAL:  r_total <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_adv        = !r_out_valid || o_rate.ready;
    assign i_step.ready = w_adv;

    always_comb begin
        w_decay    = r_total - r_warm;
        w_elapsed  = (i_step.step_index > r_warm) ? i_step.step_index - r_warm : '0;
        w_prod     = PROD_W'(r_peak) * PROD_W'(i_step.step_index);
        w_dividend = PROD_W'(w_elapsed) << FRAC_W;
        n_div0          = '0;
        n_div0.tag.mode = MODE_INVALID;
        if ((r_floor > r_peak) || (r_total == '0) || (r_warm > r_total)) begin
            n_div0.tag.mode = MODE_INVALID;
        end else if ((r_warm != '0) && (i_step.step_index < r_warm)) begin
            n_div0.tag.mode = MODE_WARM;
            {n_div0.rem, n_div0.acc} = w_prod;
            n_div0.dvsr     = r_warm;
        end else if (r_total == r_warm) begin
            n_div0.tag.mode = MODE_FLOOR;
        end else begin
            n_div0.tag.mode = MODE_DECAY;
            n_div0.tag.full = w_elapsed >= w_decay;
            n_div0.dvsr     = w_decay;
            if (w_elapsed < w_decay) begin
                {n_div0.rem, n_div0.acc} = w_dividend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (w_adv) begin
            r_vld0 <= i_step.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_div0 <= n_div0;
        end
    end

    assign w_chain[0] = r_div0;
    assign w_vld[0]   = r_vld0;

    for (genvar g = 0; g < RATE_W; g++) begin : g_cell
        wlr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vld[g]),
            .i_div   (w_chain[g]),
            .o_valid (w_vld[g+1]),
            .o_div   (w_chain[g+1])
        );
    end

    wlr_cos_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_vld[RATE_W]),
        .i_tag   (w_chain[RATE_W].tag),
        .i_quot  (w_chain[RATE_W].acc),
        .o_valid (w_vld_i),
        .o_tag   (w_tag_i),
        .o_quot  (w_quot_i),
        .o_cos   (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld_c     <= w_vld_i;
            r_out_valid <= r_vld_c;
        end
    end

    always_comb begin
        case (r_tag_c.mode)
            MODE_WARM:  n_rate = r_quot_c;
            MODE_FLOOR: n_rate = r_floor;
            MODE_DECAY: n_rate = r_floor + r_span[FRAC_W +: RATE_W];
            default:    n_rate = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag_c  <= w_tag_i;
            r_quot_c <= w_quot_i;
            r_span   <= SPAN_W'(r_peak - r_floor) * SPAN_W'(w_cos);
            r_rate   <= n_rate;
            r_status <= r_tag_c.mode == MODE_INVALID;
        end
    end

    assign o_rate.valid  = r_out_valid;
    assign o_rate.rate   = r_rate;
    assign o_rate.status = r_status;

endmodule

// File: sv/wlr_div_cell.sv
`timescale 1ns / 1ps

module wlr_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  wlr_pkg::t_div i_div,
    output logic          o_valid,
    output wlr_pkg::t_div o_div
);
    import wlr_pkg::*;

    logic              r_valid;
    t_div              r_div;
    t_div              n_div;
    logic [STEP_W:0]   w_trial;
    logic [STEP_W:0]   w_diff;
    logic              w_ge;

    always_comb begin
        w_trial = {i_div.rem, i_div.acc[RATE_W-1]};
        w_diff  = w_trial - {1'b0, i_div.dvsr};
        w_ge    = w_trial >= {1'b0, i_div.dvsr};
        n_div      = i_div;
        n_div.rem  = w_ge ? w_diff[STEP_W-1:0] : w_trial[STEP_W-1:0];
        n_div.acc  = {i_div.acc[RATE_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

// File: sv/wlr_cos_interp.sv
`timescale 1ns / 1ps

module wlr_cos_interp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  wlr_pkg::t_tag              i_tag,
    input  logic [wlr_pkg::RATE_W-1:0] i_quot,
    output logic                       o_valid,
    output wlr_pkg::t_tag              o_tag,
    output logic [wlr_pkg::RATE_W-1:0] o_quot,
    output logic [wlr_pkg::V_W-1:0]    o_cos
);
    import wlr_pkg::*;

    logic [V_W-1:0]      w_p;
    logic [POS_W-1:0]    w_pos;
    logic [IDX_W-1:0]    w_idx0;
    logic [IDX_W-1:0]    w_idx1;
    logic                w_end;
    logic [V_W-1:0]      w_t0;
    logic [V_W-1:0]      w_t1;
    logic [V_W+FRAC_W-1:0] w_mul;
    logic [V_W-1:0]      w_adj;

    logic                r_valid_a;
    t_tag                r_tag_a;
    logic [RATE_W-1:0]   r_quot_a;
    logic [V_W-1:0]      r_t0;
    logic [V_W-1:0]      r_diff;
    logic                r_dec;
    logic [FRAC_W-1:0]   r_frac;

    logic                r_valid_b;
    t_tag                r_tag_b;
    logic [RATE_W-1:0]   r_quot_b;
    logic [V_W-1:0]      r_cos;

    always_comb begin
        w_p    = i_tag.full ? ONE_Q16 : {1'b0, i_quot[FRAC_W-1:0]};
        w_pos  = POS_W'(w_p) * POS_W'(COS_TABLE_DEPTH);
        w_idx0 = w_pos[FRAC_W +: IDX_W];
        w_end  = w_idx0 >= IDX_W'(COS_TABLE_DEPTH);
        w_idx1 = w_end ? IDX_W'(COS_TABLE_DEPTH) : w_idx0 + IDX_W'(1);
        w_t0   = w_end ? COS_ROM[COS_TABLE_DEPTH] : COS_ROM[w_idx0];
        w_t1   = COS_ROM[w_idx1];
        w_mul  = r_diff * r_frac;
        w_adj  = w_mul[FRAC_W +: V_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag_a  <= i_tag;
            r_quot_a <= i_quot;
            r_t0     <= w_t0;
            r_dec    <= w_t0 >= w_t1;
            r_diff   <= (w_t0 >= w_t1) ? w_t0 - w_t1 : w_t1 - w_t0;
            r_frac   <= w_end ? '0 : w_pos[FRAC_W-1:0];
            r_tag_b  <= r_tag_a;
            r_quot_b <= r_quot_a;
            r_cos    <= r_dec ? r_t0 - w_adj : r_t0 + w_adj;
        end
    end

    assign o_valid = r_valid_b;
    assign o_tag   = r_tag_b;
    assign o_quot  = r_quot_b;
    assign o_cos   = r_cos;

endmodule
